>>> rtl/htc_pkg.sv
`default_nettype none

package htc_pkg;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_UP    = 2'd1,
        REQ_DOWN  = 2'd2,
        REQ_POWER = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        CFG_STORED_SETPOINT = 3'd0,
        CFG_INITIAL_TEMP    = 3'd1,
        CFG_SET_WINDOW      = 3'd2,
        CFG_SAMPLE_PERIOD   = 3'd3,
        CFG_BLINK_PERIOD    = 3'd4
    } cfg_index_t;

    localparam logic [7:0]  SP_MAX           = 8'd75;
    localparam logic [7:0]  SP_MIN           = 8'd35;
    localparam logic [7:0]  SP_STEP          = 8'd5;
    localparam logic [7:0]  SP_BAND          = 8'd5;
    localparam logic [7:0]  SP_DEFAULT       = 8'd60;
    localparam logic [7:0]  SP_ERASED        = 8'hFF;

    localparam logic [7:0]  RST_SETPOINT     = 8'd60;
    localparam logic [7:0]  RST_INIT_TEMP    = 8'd0;
    localparam logic [15:0] RST_SET_WINDOW   = 16'd152;
    localparam logic [15:0] RST_SAMPLE_PER   = 16'd3;
    localparam logic [7:0]  RST_BLINK_PER    = 8'd30;

    typedef struct packed {
        logic       power_state;
        logic [7:0] save_value;
        logic       save_valid;
        logic [7:0] display_value;
        logic       cooler_led;
        logic       heater_led;
        logic       cooler_on;
        logic       heater_on;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/htc_cell.sv
`default_nettype none

module htc_cell (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       fill,
    input  wire logic [7:0] fill_value,
    input  wire logic       shift,
    input  wire logic [7:0] shift_in,
    output logic      [7:0] value
);
    import htc_pkg::*;

    logic [7:0] value_reg;
    logic [7:0] value_next;

    always_comb begin
        value_next = value_reg;
        if (fill) begin
            value_next = fill_value;
        end else if (shift) begin
            value_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= RST_INIT_TEMP;
        end else begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

>>> rtl/htc_out_skid.sv
`default_nettype none

module htc_out_skid (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire htc_pkg::result_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output htc_pkg::result_t      out_data
);
    import htc_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg, main_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    push, pop;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = main_valid_reg && out_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_data_next  = skid_data_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_data_next  = in_data;
                main_valid_next = push;
            end
        end else if (push) begin
            // Main entry is stalled, so the new transfer parks in the skid entry.
            skid_data_next  = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

`default_nettype wire

>>> rtl/heater_thermostat_controller.sv
// A result is registered in the output buffer before it appears on the m_ side.
// Throughput: one item per cycle while s_tready is high; the per-item update is
// a combinational pass over the counters, running ring sum and sample cell chain.
// A two-entry output buffer keeps s_tready high until two results are stalled.
// Reset: synchronous, active-low aresetn restores the setpoint, the sample chain,
// the counters and other control registers to defaults; buffer data is not reset.
`default_nettype none

module heater_thermostat_controller #(
    parameter int RING_DEPTH = 10
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] temperature
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] heater_on, [1] cooler_on, [2] heater_led, [3] cooler_led,
    // [11:4] display_value, [12] save_valid, [20:13] save_value,
    // [21] power_state, [23:22] zero
    output logic [23:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import htc_pkg::*;

    localparam int SUM_W = $clog2(255 * RING_DEPTH + 1);
    localparam int TH_W  = $clog2(261 * RING_DEPTH + 1);

    logic [15:0] set_window_reg, set_window_next;
    logic [15:0] sample_per_reg, sample_per_next;
    logic [7:0]  blink_per_reg, blink_per_next;
    logic [7:0]  setpoint_reg, setpoint_next;
    logic        powered_reg, powered_next;
    logic [15:0] window_cnt_reg, window_cnt_next;
    logic [15:0] sample_cnt_reg, sample_cnt_next;
    logic [7:0]  blink_cnt_reg, blink_cnt_next;
    logic [7:0]  last_sample_reg, last_sample_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic        heat_reg, heat_next;
    logic        cool_reg, cool_next;
    logic        hled_reg, hled_next;
    logic        cled_reg, cled_next;

    logic [7:0]  cell_value [RING_DEPTH];
    logic        accept;
    logic        ring_fill;
    logic        ring_shift;
    logic        save;
    logic        heat_cond, cool_cond;
    logic [TH_W-1:0] lo_th, hi_th;
    req_t        req;
    result_t     res;
    result_t     out_res;
    logic        res_ready;

    assign accept = s_tvalid && s_tready;
    assign req    = req_t'(s_tuser);

    always_comb begin
        set_window_next  = set_window_reg;
        sample_per_next  = sample_per_reg;
        blink_per_next   = blink_per_reg;
        setpoint_next    = setpoint_reg;
        powered_next     = powered_reg;
        window_cnt_next  = window_cnt_reg;
        sample_cnt_next  = sample_cnt_reg;
        blink_cnt_next   = blink_cnt_reg;
        last_sample_next = last_sample_reg;
        sum_next         = sum_reg;
        heat_next        = heat_reg;
        cool_next        = cool_reg;
        hled_next        = hled_reg;
        cled_next        = cled_reg;
        ring_fill        = 1'b0;
        ring_shift       = 1'b0;
        save             = 1'b0;
        heat_cond        = 1'b0;
        cool_cond        = 1'b0;
        lo_th            = '0;
        hi_th            = '0;

        if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_STORED_SETPOINT: begin
                    setpoint_next = (cfg_wdata[7:0] == SP_ERASED) ? SP_DEFAULT
                                                                  : cfg_wdata[7:0];
                end
                CFG_INITIAL_TEMP: begin
                    ring_fill        = 1'b1;
                    last_sample_next = cfg_wdata[7:0];
                    sum_next         = SUM_W'(cfg_wdata[7:0]) * SUM_W'(RING_DEPTH);
                end
                CFG_SET_WINDOW:    set_window_next = cfg_wdata;
                CFG_SAMPLE_PERIOD: sample_per_next = cfg_wdata;
                CFG_BLINK_PERIOD: begin
                    blink_per_next = cfg_wdata[7:0];
                    blink_cnt_next = cfg_wdata[7:0];
                end
                default: ;
            endcase
        end else if (accept) begin
            case (req)
                REQ_POWER: begin
                    powered_next = !powered_reg;
                    if (powered_reg) begin
                        heat_next = 1'b0;
                        cool_next = 1'b0;
                        hled_next = 1'b0;
                        cled_next = 1'b0;
                    end
                end
                REQ_TICK: begin
                    if (powered_reg) begin
                        if (sample_cnt_reg != 16'd0) sample_cnt_next = sample_cnt_reg - 16'd1;
                        if (blink_cnt_reg != 8'd0) blink_cnt_next = blink_cnt_reg - 8'd1;
                        if (window_cnt_reg != 16'd0) begin
                            window_cnt_next = window_cnt_reg - 16'd1;
                            save = (window_cnt_reg == 16'd1);
                        end
                    end
                end
                REQ_UP: begin
                    if (powered_reg) begin
                        if (setpoint_reg < SP_MAX && window_cnt_reg != 16'd0) begin
                            setpoint_next = setpoint_reg + SP_STEP;
                        end
                        window_cnt_next = set_window_reg;
                    end
                end
                REQ_DOWN: begin
                    if (powered_reg) begin
                        if (setpoint_reg > SP_MIN && window_cnt_reg != 16'd0) begin
                            setpoint_next = setpoint_reg - SP_STEP;
                        end
                        window_cnt_next = set_window_reg;
                    end
                end
                default: ;
            endcase

            if (powered_next) begin
                if (sample_cnt_next == 16'd0) begin
                    sample_cnt_next  = sample_per_reg;
                    last_sample_next = s_tdata;
                    ring_shift       = 1'b1;
                    // The running sum drops the oldest sample as the chain shifts.
                    sum_next = sum_reg + SUM_W'(s_tdata) - SUM_W'(cell_value[RING_DEPTH-1]);
                end
                lo_th = TH_W'(8'(setpoint_next - SP_BAND)) * TH_W'(RING_DEPTH);
                hi_th = (TH_W'(setpoint_next) + TH_W'(SP_BAND) + TH_W'(1))
                        * TH_W'(RING_DEPTH);
                // floor(sum / depth) < k is the same test as sum < k * depth.
                heat_cond = (setpoint_next >= SP_BAND) && (TH_W'(sum_next) < lo_th);
                cool_cond = (TH_W'(sum_next) >= hi_th);
                if (heat_cond) begin
                    if (!heat_reg) begin
                        heat_next = 1'b1;
                        cool_next = 1'b0;
                        hled_next = 1'b0;
                        cled_next = 1'b0;
                    end
                end else if (cool_cond) begin
                    if (!cool_reg) begin
                        cool_next = 1'b1;
                        heat_next = 1'b0;
                        hled_next = 1'b0;
                        cled_next = 1'b0;
                    end
                end
                if (blink_cnt_next == 8'd0) begin
                    if (cool_next) begin
                        blink_cnt_next = blink_per_reg;
                        cled_next      = !cled_next;
                    end else if (heat_next) begin
                        blink_cnt_next = blink_per_reg;
                        hled_next      = !hled_next;
                    end
                end
            end
        end
    end

    always_comb begin
        res = '0;
        if (powered_next) begin
            res.heater_on     = heat_next;
            res.cooler_on     = cool_next;
            res.heater_led    = hled_next;
            res.cooler_led    = cled_next;
            res.display_value = (window_cnt_next != 16'd0) ? setpoint_next : last_sample_next;
            res.save_valid    = save;
            res.save_value    = save ? setpoint_next : 8'd0;
            res.power_state   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_window_reg  <= RST_SET_WINDOW;
            sample_per_reg  <= RST_SAMPLE_PER;
            blink_per_reg   <= RST_BLINK_PER;
            setpoint_reg    <= RST_SETPOINT;
            powered_reg     <= 1'b0;
            window_cnt_reg  <= 16'd0;
            sample_cnt_reg  <= 16'd0;
            blink_cnt_reg   <= RST_BLINK_PER;
            last_sample_reg <= RST_INIT_TEMP;
            sum_reg         <= SUM_W'(RST_INIT_TEMP) * SUM_W'(RING_DEPTH);
            heat_reg        <= 1'b0;
            cool_reg        <= 1'b0;
            hled_reg        <= 1'b0;
            cled_reg        <= 1'b0;
        end else begin
            set_window_reg  <= set_window_next;
            sample_per_reg  <= sample_per_next;
            blink_per_reg   <= blink_per_next;
            setpoint_reg    <= setpoint_next;
            powered_reg     <= powered_next;
            window_cnt_reg  <= window_cnt_next;
            sample_cnt_reg  <= sample_cnt_next;
            blink_cnt_reg   <= blink_cnt_next;
            last_sample_reg <= last_sample_next;
            sum_reg         <= sum_next;
            heat_reg        <= heat_next;
            cool_reg        <= cool_next;
            hled_reg        <= hled_next;
            cled_reg        <= cled_next;
        end
    end

    // Sample history: stored samples enter cell 0 and shift on to each next cell.
    for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
        logic [7:0] shift_src;
        if (i == 0) begin : g_head
            assign shift_src = s_tdata;
        end else begin : g_body
            assign shift_src = cell_value[i-1];
        end
        htc_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .fill       (ring_fill),
            .fill_value (cfg_wdata[7:0]),
            .shift      (ring_shift),
            .shift_in   (shift_src),
            .value      (cell_value[i])
        );
    end

    htc_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_ready  (res_ready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign s_tready = res_ready;
    assign m_tdata  = {2'b00, out_res.power_state, out_res.save_value, out_res.save_valid,
                       out_res.display_value, out_res.cooler_led, out_res.heater_led,
                       out_res.cooler_on, out_res.heater_on};

    a_one_actuator: assert property (@(posedge aclk) disable iff (!aresetn)
        !(heat_reg && cool_reg))
        else $error("heater and cooler driven together");

    a_led_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (hled_reg |-> heat_reg) and (cled_reg |-> cool_reg))
        else $error("LED lit without its actuator");

    a_off_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !powered_reg |-> !(heat_reg || cool_reg || hled_reg || cled_reg))
        else $error("actuator active while powered off");

    a_save_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !cfg_we && save) |=> (window_cnt_reg == 16'd0))
        else $error("save issued while window still open");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

endmodule

`default_nettype wire
